// ----- design/svbm_pkg.sv -----
// ----------------------------------------------------------------------------
// svbm_pkg: shared definitions for the volume block mapper
// Field widths, block map constants, operation and region codes, and the
// sequencer state type.
// ----------------------------------------------------------------------------
package svbm_pkg;

  // Volume layout
  localparam int MAX_ENTRIES  = 32;
  localparam int INDEX_BASE   = 22;
  localparam int DATA_START   = 64;
  localparam int FILE_SPAN    = 2048;
  localparam int SUBDIR_START = 1024;
  localparam int ROOT_LIMIT   = 50;

  // Field widths
  localparam int OP_W     = 2;
  localparam int BLOCK_W  = 24;
  localparam int SIZE_W   = 21;
  localparam int REGION_W = 3;
  localparam int WORD_W   = 64;
  localparam int WIDX_W   = 6;
  localparam int FNUM_W   = 5;
  localparam int FBLK_W   = 11;
  localparam int SDN_W    = 6;
  localparam int SDB_W    = 2;

  // Derived widths
  localparam int SPAN_W      = $clog2(FILE_SPAN);
  localparam int SLOT_W      = BLOCK_W - SPAN_W;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int COUNT_W     = $clog2(MAX_ENTRIES + 1);
  localparam int BLK_BYTES_W = 9;
  localparam int NEED_W      = SIZE_W - BLK_BYTES_W;
  localparam int SPAN_CNT_W  = 7;
  localparam int WORDS       = 64;

  // Typed constants
  localparam logic [SIZE_W-1:0]     SIZE_CAP        = SIZE_W'(1048576);
  localparam logic [COUNT_W-1:0]    COUNT_FULL      = COUNT_W'(MAX_ENTRIES);
  localparam logic [WIDX_W-1:0]     WORD_LAST       = WIDX_W'(WORDS - 1);
  localparam logic [BLOCK_W-1:0]    BN_BOOT_LAST    = BLOCK_W'(1);
  localparam logic [BLOCK_W-1:0]    BN_DIR_FIRST    = BLOCK_W'(2);
  localparam logic [BLOCK_W-1:0]    BN_DIR_LAST     = BLOCK_W'(5);
  localparam logic [BLOCK_W-1:0]    BN_BITMAP_FIRST = BLOCK_W'(6);
  localparam logic [BLOCK_W-1:0]    BN_INDEX_BASE   = BLOCK_W'(INDEX_BASE);
  localparam logic [BLOCK_W-1:0]    BN_DATA_START   = BLOCK_W'(DATA_START);
  localparam logic [BLOCK_W-1:0]    BN_SUBDIR_START = BLOCK_W'(SUBDIR_START);
  localparam logic [BLOCK_W-1:0]    BN_SUBDIR_END   = BLOCK_W'(SUBDIR_START + 4 * ROOT_LIMIT);
  localparam logic [SPAN_CNT_W-1:0] BITMAP_LIMIT    = SPAN_CNT_W'(64);
  localparam logic [SPAN_CNT_W-1:0] INDEX_LIMIT     = SPAN_CNT_W'(8);

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_READ   = 2'd2,
    OP_WRITE  = 2'd3
  } op_t;

  typedef enum logic [REGION_W-1:0] {
    REG_BOOT   = 3'd0,
    REG_DIR    = 3'd1,
    REG_BITMAP = 3'd2,
    REG_SUBDIR = 3'd3,
    REG_INDEX  = 3'd4,
    REG_DATA   = 3'd5,
    REG_ZERO   = 3'd6,
    REG_ACK    = 3'd7
  } region_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_DECODE = 3'b010,
    ST_EMIT   = 3'b100
  } state_t;

endpackage

// ----- design/svbm_cmd_if.sv -----
// ----------------------------------------------------------------------------
// svbm_cmd_if: command channel of the volume block mapper
// Valid/ready handshake carrying one command word.
// ----------------------------------------------------------------------------
interface svbm_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [svbm_pkg::OP_W-1:0]    operation;
  logic [svbm_pkg::BLOCK_W-1:0] block_number;
  logic [svbm_pkg::SIZE_W-1:0]  entry_size;
  logic                         entry_is_directory;

  modport source (
    output valid, operation, block_number, entry_size, entry_is_directory,
    input  ready
  );

  modport sink (
    input  valid, operation, block_number, entry_size, entry_is_directory,
    output ready
  );
endinterface

// ----- design/svbm_rsp_if.sv -----
// ----------------------------------------------------------------------------
// svbm_rsp_if: response channel of the volume block mapper
// Valid/ready handshake carrying one block word or descriptor.
// ----------------------------------------------------------------------------
interface svbm_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [svbm_pkg::REGION_W-1:0] region;
  logic                          status;
  logic [svbm_pkg::WORD_W-1:0]   word_data;
  logic [svbm_pkg::WIDX_W-1:0]   word_index;
  logic                          last;
  logic [svbm_pkg::FNUM_W-1:0]   file_number;
  logic [svbm_pkg::FBLK_W-1:0]   file_block;
  logic [svbm_pkg::SDN_W-1:0]    subdir_number;
  logic [svbm_pkg::SDB_W-1:0]    subdir_block;

  modport source (
    output valid, region, status, word_data, word_index, last, file_number,
           file_block, subdir_number, subdir_block,
    input  ready
  );

  modport sink (
    input  valid, region, status, word_data, word_index, last, file_number,
           file_block, subdir_number, subdir_block,
    output ready
  );
endinterface

// ----- design/svbm_ram.sv -----
// ----------------------------------------------------------------------------
// svbm_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module svbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and register the read word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- design/svbm_span_unit.sv -----
// ----------------------------------------------------------------------------
// svbm_span_unit: shared subtract and saturate unit
// Computes a - b clamped to [0, limit], and flags a > b. Serves the bitmap
// used-bit count, the index pointer count and the file size growth test.
// ----------------------------------------------------------------------------
module svbm_span_unit (
  input  logic [svbm_pkg::SIZE_W-1:0]     a,
  input  logic [svbm_pkg::SIZE_W-1:0]     b,
  input  logic [svbm_pkg::SPAN_CNT_W-1:0] limit,
  output logic [svbm_pkg::SPAN_CNT_W-1:0] span,
  output logic                            exceeds
);

  logic [svbm_pkg::SIZE_W:0] diff;

  // Subtract with one extra bit for the sign
  assign diff = {1'b0, a} - {1'b0, b};

  // Clamp the difference into the window
  always_comb begin
    exceeds = !diff[svbm_pkg::SIZE_W] && (diff != '0);
    if (diff[svbm_pkg::SIZE_W]) begin
      span = '0;
    end else if (diff > (svbm_pkg::SIZE_W + 1)'(limit)) begin
      span = limit;
    end else begin
      span = diff[svbm_pkg::SPAN_CNT_W-1:0];
    end
  end

endmodule

// ----- design/synthetic_volume_block_mapper.sv -----
// ----------------------------------------------------------------------------
// synthetic_volume_block_mapper: file table and volume block decoder
// Flow: a command is taken while idle, decoded, then emitted one word per cycle
//   while the response channel takes words: 64 words for boot, bitmap, index
//   and zero-fill reads, one word for every other command. A new command is
//   taken only after the last word is loaded; the size table has a single
//   read port.
// Reset: clears the entry count, directory flags, sequencer and output valid.
//   The size table is not cleared; it is only read for files in use.
// ----------------------------------------------------------------------------
module synthetic_volume_block_mapper (
  input  logic     clk,
  input  logic     rst,
  svbm_cmd_if.sink   cmd,
  svbm_rsp_if.source rsp
);

  // Sequencer and command registers
  svbm_pkg::state_t               state;
  svbm_pkg::state_t               state_next;
  svbm_pkg::op_t                  op;
  svbm_pkg::region_t              region;
  svbm_pkg::region_t              region_next;
  logic [svbm_pkg::BLOCK_W-1:0]   block_number;
  logic [svbm_pkg::SIZE_W-1:0]    entry_size;
  logic                           entry_is_directory;
  logic [svbm_pkg::WIDX_W-1:0]    word_count;
  logic [svbm_pkg::WIDX_W-1:0]    word_count_next;

  // File table; a slot is in use exactly when it lies below entry_count
  logic [svbm_pkg::COUNT_W-1:0]     entry_count;
  logic [svbm_pkg::MAX_ENTRIES-1:0] dir_flags;

  // Output register
  logic                          out_valid;
  logic [svbm_pkg::REGION_W-1:0] out_region;
  logic                          out_status;
  logic [svbm_pkg::WORD_W-1:0]   out_word_data;
  logic [svbm_pkg::WIDX_W-1:0]   out_word_index;
  logic                          out_last;
  logic [svbm_pkg::FNUM_W-1:0]   out_file_number;
  logic [svbm_pkg::FBLK_W-1:0]   out_file_block;
  logic [svbm_pkg::SDN_W-1:0]    out_subdir_number;
  logic [svbm_pkg::SDB_W-1:0]    out_subdir_block;

  // Next word
  logic                          status_n;
  logic [svbm_pkg::WORD_W-1:0]   word_data_n;
  logic                          last_n;
  logic [svbm_pkg::FNUM_W-1:0]   file_number_n;
  logic [svbm_pkg::FBLK_W-1:0]   file_block_n;
  logic [svbm_pkg::SDN_W-1:0]    subdir_number_n;
  logic [svbm_pkg::SDB_W-1:0]    subdir_block_n;

  // Datapath
  logic                            accept;
  logic                            load;
  logic                            multi;
  logic [svbm_pkg::SLOT_W-1:0]     slot;
  logic [svbm_pkg::SLOT_W-1:0]     slot_ahead;
  logic                            slot_ok;
  logic                            file_ok;
  logic                            is_data_blk;
  logic [svbm_pkg::SIZE_W-1:0]     size_rd;
  logic [svbm_pkg::NEED_W-1:0]     need;
  logic [svbm_pkg::BLOCK_W-1:0]    data_rel;
  logic [svbm_pkg::FBLK_W-1:0]     file_block_cur;
  logic [svbm_pkg::SIZE_W-1:0]     grow_size;
  logic [svbm_pkg::SIZE_W-1:0]     sat_size;
  logic [15:0]                     bmp_base;
  logic [15:0]                     bmp_rel;
  logic                            bmp_low;
  logic [svbm_pkg::SIZE_W-1:0]     unit_a;
  logic [svbm_pkg::SIZE_W-1:0]     unit_b;
  logic [svbm_pkg::SPAN_CNT_W-1:0] unit_limit;
  logic [svbm_pkg::SPAN_CNT_W-1:0] unit_span;
  logic                            unit_exceeds;
  logic [svbm_pkg::SPAN_CNT_W-1:0] used;
  logic [svbm_pkg::WORD_W-1:0]     bitmap_word;
  logic [svbm_pkg::WORD_W-1:0]     index_word;
  logic [7:0]                      sub_rel;
  logic                            ram_wr_en;
  logic [svbm_pkg::IDX_W-1:0]      ram_wr_addr;
  logic [svbm_pkg::SIZE_W-1:0]     ram_wr_data;

  // Table slot that a block touches: bitmap words map to the file they cover
  function automatic logic [svbm_pkg::SLOT_W-1:0] slot_of(
    input logic [svbm_pkg::BLOCK_W-1:0] bn,
    input logic [svbm_pkg::WIDX_W-1:0]  w
  );
    logic [3:0]                   bmp;
    logic [15:0]                  base;
    logic [15:0]                  rel;
    logic [svbm_pkg::BLOCK_W-1:0] drel;
    bmp  = 4'(bn - svbm_pkg::BN_BITMAP_FIRST);
    base = {bmp, w, 6'd0};
    rel  = base - 16'(svbm_pkg::DATA_START);
    drel = bn - svbm_pkg::BN_DATA_START;
    if (bn < svbm_pkg::BN_INDEX_BASE) begin
      slot_of = svbm_pkg::SLOT_W'(rel[15:svbm_pkg::SPAN_W]);
    end else if (bn < svbm_pkg::BN_DATA_START) begin
      slot_of = svbm_pkg::SLOT_W'(bn - svbm_pkg::BN_INDEX_BASE);
    end else begin
      slot_of = drel[svbm_pkg::BLOCK_W-1:svbm_pkg::SPAN_W];
    end
  endfunction

  // Handshakes
  assign cmd.ready = (state == svbm_pkg::ST_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign load      = (state == svbm_pkg::ST_EMIT) && (!out_valid || rsp.ready);

  assign multi  = region inside {svbm_pkg::REG_BOOT, svbm_pkg::REG_BITMAP,
                                 svbm_pkg::REG_INDEX, svbm_pkg::REG_ZERO};
  assign last_n = !multi || (word_count == svbm_pkg::WORD_LAST);

  // Advance the word counter; restart it on each new command
  always_comb begin
    if (accept) begin
      word_count_next = '0;
    end else if (load) begin
      word_count_next = word_count + svbm_pkg::WIDX_W'(1);
    end else begin
      word_count_next = word_count;
    end
  end

  // Slot lookups: one for the current word, one for the next word count, which addresses the registered table read
  assign slot       = slot_of(block_number, word_count);
  assign slot_ahead = slot_of(block_number, word_count_next);
  assign slot_ok    = slot < svbm_pkg::SLOT_W'(entry_count);
  assign file_ok    = slot_ok && !dir_flags[slot[svbm_pkg::IDX_W-1:0]];

  // File block geometry
  assign is_data_blk    = block_number >= svbm_pkg::BN_DATA_START;
  assign data_rel       = block_number - svbm_pkg::BN_DATA_START;
  assign file_block_cur = data_rel[svbm_pkg::FBLK_W-1:0];
  assign grow_size      = {svbm_pkg::NEED_W'(file_block_cur) + svbm_pkg::NEED_W'(1),
                           {svbm_pkg::BLK_BYTES_W{1'b0}}};
  assign sat_size       = (entry_size > svbm_pkg::SIZE_CAP) ? svbm_pkg::SIZE_CAP
                                                            : entry_size;

  // Blocks a file needs, rounded up
  assign need = size_rd[svbm_pkg::SIZE_W-1:svbm_pkg::BLK_BYTES_W]
              + svbm_pkg::NEED_W'(|size_rd[svbm_pkg::BLK_BYTES_W-1:0]);

  // Bitmap word geometry
  assign bmp_base = {4'(block_number - svbm_pkg::BN_BITMAP_FIRST), word_count, 6'd0};
  assign bmp_low  = bmp_base < 16'(svbm_pkg::DATA_START);
  assign bmp_rel  = bmp_base - 16'(svbm_pkg::DATA_START);

  // Route operands to the shared unit
  always_comb begin
    case (region)
      svbm_pkg::REG_BITMAP: begin
        unit_a     = svbm_pkg::SIZE_W'(need);
        unit_b     = svbm_pkg::SIZE_W'(bmp_rel[svbm_pkg::SPAN_W-1:0]);
        unit_limit = svbm_pkg::BITMAP_LIMIT;
      end
      svbm_pkg::REG_INDEX: begin
        unit_a     = svbm_pkg::SIZE_W'(need);
        unit_b     = svbm_pkg::SIZE_W'({word_count[4:0], 3'd0});
        unit_limit = svbm_pkg::INDEX_LIMIT;
      end
      default: begin
        unit_a     = grow_size;
        unit_b     = size_rd;
        unit_limit = '0;
      end
    endcase
  end

  svbm_span_unit u_span (
    .a       (unit_a),
    .b       (unit_b),
    .limit   (unit_limit),
    .span    (unit_span),
    .exceeds (unit_exceeds)
  );

  assign used = slot_ok ? unit_span : '0;

  // Free-space bits: set for blocks past the used span, MSB first per byte
  always_comb begin
    bitmap_word = '0;
    for (int j = 0; j < 64; j++) begin
      bitmap_word[8 * (j / 8) + 7 - (j % 8)] = !bmp_low
                                              && (svbm_pkg::SPAN_CNT_W'(j) >= used);
    end
  end

  // Index pointers: low bytes in the first half, high bytes in the second
  always_comb begin
    logic [7:0]  ib;
    logic [15:0] db;
    index_word = '0;
    for (int m = 0; m < 8; m++) begin
      ib = {word_count[4:0], 3'(m)};
      db = 16'(svbm_pkg::DATA_START) + {slot[4:0], 11'd0} + {8'd0, ib};
      if (svbm_pkg::SPAN_CNT_W'(m) < used) begin
        index_word[8 * m +: 8] = word_count[5] ? db[15:8] : db[7:0];
      end
    end
  end

  // Decode the region of a command
  always_comb begin
    case (op)
      svbm_pkg::OP_READ: begin
        if (block_number <= svbm_pkg::BN_BOOT_LAST) begin
          region_next = svbm_pkg::REG_BOOT;
        end else if (block_number <= svbm_pkg::BN_DIR_LAST) begin
          region_next = svbm_pkg::REG_DIR;
        end else if (block_number < svbm_pkg::BN_INDEX_BASE) begin
          region_next = svbm_pkg::REG_BITMAP;
        end else if (block_number >= svbm_pkg::BN_SUBDIR_START &&
                     block_number < svbm_pkg::BN_SUBDIR_END) begin
          region_next = svbm_pkg::REG_SUBDIR;
        end else if (block_number < svbm_pkg::BN_DATA_START) begin
          region_next = svbm_pkg::REG_INDEX;
        end else if (file_ok) begin
          region_next = svbm_pkg::REG_DATA;
        end else begin
          region_next = svbm_pkg::REG_ZERO;
        end
      end
      default: region_next = svbm_pkg::REG_ACK;
    endcase
  end

  // Build the next word
  assign sub_rel = 8'(block_number - svbm_pkg::BN_SUBDIR_START);

  always_comb begin
    status_n        = 1'b0;
    word_data_n     = '0;
    file_number_n   = '0;
    file_block_n    = '0;
    subdir_number_n = '0;
    subdir_block_n  = '0;
    case (region)
      svbm_pkg::REG_BOOT: begin
        word_data_n = (word_count == '0) ? svbm_pkg::WORD_W'(1) : '0;
      end
      svbm_pkg::REG_DIR: begin
        subdir_block_n = svbm_pkg::SDB_W'(block_number - svbm_pkg::BN_DIR_FIRST);
      end
      svbm_pkg::REG_BITMAP: begin
        word_data_n = bitmap_word;
      end
      svbm_pkg::REG_SUBDIR: begin
        subdir_number_n = sub_rel[7:2];
        subdir_block_n  = sub_rel[1:0];
      end
      svbm_pkg::REG_INDEX: begin
        word_data_n   = index_word;
        file_number_n = slot[svbm_pkg::FNUM_W-1:0];
      end
      svbm_pkg::REG_DATA: begin
        file_number_n = slot[svbm_pkg::FNUM_W-1:0];
        file_block_n  = file_block_cur;
      end
      svbm_pkg::REG_ACK: begin
        if (op == svbm_pkg::OP_WRITE && is_data_blk) begin
          if (file_ok) begin
            file_number_n = slot[svbm_pkg::FNUM_W-1:0];
            file_block_n  = file_block_cur;
          end else begin
            status_n = 1'b1;
          end
        end
      end
      default: begin
        word_data_n = '0;
      end
    endcase
  end

  // Size table: append stores a new size, a data write grows it
  always_comb begin
    if (state == svbm_pkg::ST_DECODE) begin
      ram_wr_en   = (op == svbm_pkg::OP_APPEND) && (entry_count < svbm_pkg::COUNT_FULL);
      ram_wr_addr = entry_count[svbm_pkg::IDX_W-1:0];
      ram_wr_data = sat_size;
    end else begin
      ram_wr_en   = load && (op == svbm_pkg::OP_WRITE) && is_data_blk
                    && file_ok && unit_exceeds;
      ram_wr_addr = slot[svbm_pkg::IDX_W-1:0];
      ram_wr_data = grow_size;
    end
  end

  svbm_ram #(
    .WIDTH (svbm_pkg::SIZE_W),
    .DEPTH (svbm_pkg::MAX_ENTRIES)
  ) u_size_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (slot_ahead[svbm_pkg::IDX_W-1:0]),
    .rd_data (size_rd)
  );

  // Sequencer
  always_comb begin
    case (state)
      svbm_pkg::ST_IDLE:   state_next = accept ? svbm_pkg::ST_DECODE : svbm_pkg::ST_IDLE;
      svbm_pkg::ST_DECODE: state_next = svbm_pkg::ST_EMIT;
      svbm_pkg::ST_EMIT:   state_next = (load && last_n) ? svbm_pkg::ST_IDLE
                                                         : svbm_pkg::ST_EMIT;
      default:             state_next = svbm_pkg::ST_IDLE;
    endcase
  end

  // Control state and file table flags
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= svbm_pkg::ST_IDLE;
      word_count  <= '0;
      entry_count <= '0;
      dir_flags   <= '0;
      out_valid   <= 1'b0;
    end else begin
      state      <= state_next;
      word_count <= word_count_next;
      if (state == svbm_pkg::ST_DECODE) begin
        case (op)
          svbm_pkg::OP_CLEAR: begin
            entry_count <= '0;
            dir_flags   <= '0;
          end
          svbm_pkg::OP_APPEND: begin
            if (entry_count < svbm_pkg::COUNT_FULL) begin
              dir_flags[entry_count[svbm_pkg::IDX_W-1:0]] <= entry_is_directory;
              entry_count <= entry_count + svbm_pkg::COUNT_W'(1);
            end
          end
          default: begin
            entry_count <= entry_count;
          end
        endcase
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Capture the command and the decoded region
  always_ff @(posedge clk) begin
    if (accept) begin
      op                 <= svbm_pkg::op_t'(cmd.operation);
      block_number       <= cmd.block_number;
      entry_size         <= cmd.entry_size;
      entry_is_directory <= cmd.entry_is_directory;
    end
    if (state == svbm_pkg::ST_DECODE) begin
      region <= region_next;
    end
  end

  // Hold the output word until taken
  always_ff @(posedge clk) begin
    if (load) begin
      out_region        <= region;
      out_status        <= status_n;
      out_word_data     <= word_data_n;
      out_word_index    <= word_count;
      out_last          <= last_n;
      out_file_number   <= file_number_n;
      out_file_block    <= file_block_n;
      out_subdir_number <= subdir_number_n;
      out_subdir_block  <= subdir_block_n;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.region        = out_region;
  assign rsp.status        = out_status;
  assign rsp.word_data     = out_word_data;
  assign rsp.word_index    = out_word_index;
  assign rsp.last          = out_last;
  assign rsp.file_number   = out_file_number;
  assign rsp.file_block    = out_file_block;
  assign rsp.subdir_number = out_subdir_number;
  assign rsp.subdir_block  = out_subdir_block;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= svbm_pkg::COUNT_FULL)
    else $error("entry count beyond table size");

  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (load && last_n) |=> (state == svbm_pkg::ST_IDLE))
    else $error("sequencer did not return to idle after last word");

  a_word_step: assert property (@(posedge clk) disable iff (rst)
    (load && !last_n) |=> (word_count == $past(word_count) + svbm_pkg::WIDX_W'(1)))
    else $error("word counter did not advance");

  a_append_count: assert property (@(posedge clk) disable iff (rst)
    (state == svbm_pkg::ST_DECODE && op == svbm_pkg::OP_APPEND &&
     entry_count < svbm_pkg::COUNT_FULL)
    |=> (entry_count == $past(entry_count) + svbm_pkg::COUNT_W'(1)))
    else $error("append did not grow the table");

endmodule

// ----- tb/synthetic_volume_block_mapper_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// synthetic_volume_block_mapper_test: self-checking bench for the block mapper
// Drives table, read and write commands over the command channel. A local
// model of the file table predicts every response word. The response
// channel is checked word by word against the queue of predicted words.
// Both channels stall at random, except for one stretch that runs at full rate.
// ----------------------------------------------------------------------------
module synthetic_volume_block_mapper_test;

  typedef struct packed {
    svbm_pkg::region_t                 region;
    logic                              status;
    logic [svbm_pkg::WORD_W-1:0]       word_data;
    logic [svbm_pkg::WIDX_W-1:0]       word_index;
    logic                              last;
    logic [svbm_pkg::FNUM_W-1:0]       file_number;
    logic [svbm_pkg::FBLK_W-1:0]       file_block;
    logic [svbm_pkg::SDN_W-1:0]        subdir_number;
    logic [svbm_pkg::SDB_W-1:0]        subdir_block;
  } rsp_word_t;

  logic clk;
  logic rst;

  svbm_cmd_if cmd_ch ();
  svbm_rsp_if rsp_ch ();

  synthetic_volume_block_mapper DUT (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  // Local copy of the file table
  logic [svbm_pkg::SIZE_W-1:0] file_size [svbm_pkg::MAX_ENTRIES];
  logic                        file_is_dir [svbm_pkg::MAX_ENTRIES];
  logic                        file_live [svbm_pkg::MAX_ENTRIES];
  int unsigned                 file_count;

  rsp_word_t   pending_words [$];
  bit          steady;
  int unsigned failures;
  int unsigned commands_sent;
  int unsigned words_checked;
  int unsigned reads_sent;
  int unsigned writes_refused;
  int unsigned region_hits [8];

  // Clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Hard stop for a hung run
  initial begin
    #5_000_000;
    $display("%0t: timeout with %0d words still pending", $time, pending_words.size());
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic void push_word(svbm_pkg::region_t region, logic status,
                                    logic [63:0] data, int unsigned widx, logic last,
                                    int unsigned fnum, int unsigned fblk,
                                    int unsigned sdn, int unsigned sdb);
    rsp_word_t w;
    w.region        = region;
    w.status        = status;
    w.word_data     = data;
    w.word_index    = svbm_pkg::WIDX_W'(widx);
    w.last          = last;
    w.file_number   = svbm_pkg::FNUM_W'(fnum);
    w.file_block    = svbm_pkg::FBLK_W'(fblk);
    w.subdir_number = svbm_pkg::SDN_W'(sdn);
    w.subdir_block  = svbm_pkg::SDB_W'(sdb);
    pending_words.push_back(w);
  endfunction

  function automatic int unsigned blocks_of(int unsigned slot);
    return (int'(file_size[slot]) + 511) / 512;
  endfunction

  // Slot holds a plain file that reads and writes may target
  function automatic bit file_open(int unsigned slot);
    if (slot >= svbm_pkg::MAX_ENTRIES) return 1'b0;
    return file_live[slot] && !file_is_dir[slot];
  endfunction

  function automatic bit block_allocated(int unsigned blk);
    int unsigned slot;
    int unsigned fb;
    if (blk < svbm_pkg::DATA_START) return 1'b1;
    slot = (blk - svbm_pkg::DATA_START) / svbm_pkg::FILE_SPAN;
    fb   = (blk - svbm_pkg::DATA_START) % svbm_pkg::FILE_SPAN;
    if (slot >= svbm_pkg::MAX_ENTRIES || slot >= file_count) return 1'b0;
    if (!file_live[slot]) return 1'b0;
    return fb < blocks_of(slot);
  endfunction

  // Free blocks set their bit; bit order within a byte is MSB first
  function automatic logic [63:0] bitmap_bits(int unsigned map, int unsigned w);
    logic [63:0] v;
    int unsigned blk;
    v = '0;
    for (int j = 0; j < 64; j++) begin
      blk = map * 4096 + w * 64 + j;
      if (!block_allocated(blk)) v[8 * (j / 8) + 7 - (j % 8)] = 1'b1;
    end
    return v;
  endfunction

  // Low pointer bytes fill the first half of the block, high bytes the second
  function automatic logic [63:0] index_bytes(int unsigned slot, int unsigned need,
                                              int unsigned w);
    logic [63:0] v;
    int unsigned k;
    int unsigned i;
    int unsigned ptr;
    v = '0;
    for (int m = 0; m < 8; m++) begin
      k = w * 8 + m;
      i = (k < 256) ? k : k - 256;
      if (i < need) begin
        ptr = (svbm_pkg::DATA_START + slot * svbm_pkg::FILE_SPAN + i) & 32'hFFFF;
        v[8 * m +: 8] = (k < 256) ? ptr[7:0] : ptr[15:8];
      end
    end
    return v;
  endfunction

  function automatic void predict_read(int unsigned bn);
    int unsigned slot;
    int unsigned fb;
    int unsigned need;
    int unsigned rel;
    if (bn <= 1) begin
      for (int w = 0; w < 64; w++) begin
        push_word(svbm_pkg::REG_BOOT, 0, (w == 0), w, (w == 63), 0, 0, 0, 0);
      end
    end else if (bn <= 5) begin
      push_word(svbm_pkg::REG_DIR, 0, 0, 0, 1, 0, 0, 0, bn - 2);
    end else if (bn < svbm_pkg::INDEX_BASE) begin
      for (int w = 0; w < 64; w++) begin
        push_word(svbm_pkg::REG_BITMAP, 0, bitmap_bits(bn - 6, w), w, (w == 63),
                  0, 0, 0, 0);
      end
    end else if (bn >= svbm_pkg::SUBDIR_START &&
                 bn < svbm_pkg::SUBDIR_START + 4 * svbm_pkg::ROOT_LIMIT) begin
      rel = bn - svbm_pkg::SUBDIR_START;
      push_word(svbm_pkg::REG_SUBDIR, 0, 0, 0, 1, 0, 0, rel / 4, rel % 4);
    end else if (bn < svbm_pkg::DATA_START) begin
      slot = bn - svbm_pkg::INDEX_BASE;
      need = 0;
      if (slot < file_count && slot < svbm_pkg::MAX_ENTRIES) begin
        if (file_live[slot]) need = (blocks_of(slot) > 256) ? 256 : blocks_of(slot);
      end
      for (int w = 0; w < 64; w++) begin
        push_word(svbm_pkg::REG_INDEX, 0, index_bytes(slot, need, w), w, (w == 63),
                  slot, 0, 0, 0);
      end
    end else begin
      slot = (bn - svbm_pkg::DATA_START) / svbm_pkg::FILE_SPAN;
      fb   = (bn - svbm_pkg::DATA_START) % svbm_pkg::FILE_SPAN;
      if (file_open(slot)) begin
        push_word(svbm_pkg::REG_DATA, 0, 0, 0, 1, slot, fb, 0, 0);
      end else begin
        for (int w = 0; w < 64; w++) begin
          push_word(svbm_pkg::REG_ZERO, 0, 0, w, (w == 63), 0, 0, 0, 0);
        end
      end
    end
  endfunction

  function automatic void predict_write(int unsigned bn);
    int unsigned slot;
    int unsigned fb;
    int unsigned grown;
    if (bn < svbm_pkg::DATA_START) begin
      push_word(svbm_pkg::REG_ACK, 0, 0, 0, 1, 0, 0, 0, 0);
      return;
    end
    slot = (bn - svbm_pkg::DATA_START) / svbm_pkg::FILE_SPAN;
    fb   = (bn - svbm_pkg::DATA_START) % svbm_pkg::FILE_SPAN;
    if (!file_open(slot)) begin
      writes_refused++;
      push_word(svbm_pkg::REG_ACK, 1, 0, 0, 1, 0, 0, 0, 0);
      return;
    end
    grown = (fb + 1) * 512;
    if (grown > file_size[slot]) file_size[slot] = svbm_pkg::SIZE_W'(grown);
    push_word(svbm_pkg::REG_ACK, 0, 0, 0, 1, slot, fb, 0, 0);
  endfunction

  function automatic void predict_command(svbm_pkg::op_t op,
                                          logic [svbm_pkg::BLOCK_W-1:0] bn,
                                          logic [svbm_pkg::SIZE_W-1:0] sz,
                                          logic is_dir);
    case (op)
      svbm_pkg::OP_CLEAR: begin
        for (int i = 0; i < svbm_pkg::MAX_ENTRIES; i++) begin
          file_live[i]   = 1'b0;
          file_is_dir[i] = 1'b0;
        end
        file_count = 0;
        push_word(svbm_pkg::REG_ACK, 0, 0, 0, 1, 0, 0, 0, 0);
      end
      svbm_pkg::OP_APPEND: begin
        // Full table drops the entry but still acknowledges
        if (file_count < svbm_pkg::MAX_ENTRIES) begin
          file_size[file_count]   = (sz > svbm_pkg::SIZE_CAP) ? svbm_pkg::SIZE_CAP : sz;
          file_is_dir[file_count] = is_dir;
          file_live[file_count]   = 1'b1;
          file_count++;
        end
        push_word(svbm_pkg::REG_ACK, 0, 0, 0, 1, 0, 0, 0, 0);
      end
      svbm_pkg::OP_READ: begin
        reads_sent++;
        predict_read(bn);
      end
      default: predict_write(bn);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Command driver
  // ---------------------------------------------------------------------------

  // Hold the command word until it is taken, then record its responses
  task automatic send_cmd(svbm_pkg::op_t op, logic [svbm_pkg::BLOCK_W-1:0] bn,
                          logic [svbm_pkg::SIZE_W-1:0] sz, logic is_dir);
    while (!steady && $urandom_range(0, 99) < 15) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid              <= 1'b1;
    cmd_ch.operation          <= op;
    cmd_ch.block_number       <= bn;
    cmd_ch.entry_size         <= sz;
    cmd_ch.entry_is_directory <= is_dir;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    commands_sent++;
    predict_command(op, bn, sz, is_dir);
  endtask

  task automatic read_block(int unsigned bn);
    send_cmd(svbm_pkg::OP_READ, svbm_pkg::BLOCK_W'(bn), '0, 1'b0);
  endtask

  task automatic write_block(int unsigned bn);
    send_cmd(svbm_pkg::OP_WRITE, svbm_pkg::BLOCK_W'(bn), '0, 1'b0);
  endtask

  task automatic append_file(int unsigned sz, logic is_dir);
    send_cmd(svbm_pkg::OP_APPEND, '0, svbm_pkg::SIZE_W'(sz), is_dir);
  endtask

  // Pause the sender until every predicted word has come back
  task automatic await_results();
    cmd_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Response checker
  // ---------------------------------------------------------------------------

  task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      failures++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  task automatic check_word();
    rsp_word_t want;
    if (pending_words.size() == 0) begin
      failures++;
      $display("%0t: unexpected response word, expected none, actual region %0d",
               $time, rsp_ch.region);
      return;
    end
    want = pending_words.pop_front();
    words_checked++;
    region_hits[rsp_ch.region]++;
    compare_field("region", want.region, rsp_ch.region);
    compare_field("status", want.status, rsp_ch.status);
    compare_field("word_data", want.word_data, rsp_ch.word_data);
    compare_field("word_index", want.word_index, rsp_ch.word_index);
    compare_field("last", want.last, rsp_ch.last);
    compare_field("file_number", want.file_number, rsp_ch.file_number);
    compare_field("file_block", want.file_block, rsp_ch.file_block);
    compare_field("subdir_number", want.subdir_number, rsp_ch.subdir_number);
    compare_field("subdir_block", want.subdir_block, rsp_ch.subdir_block);
  endtask

  // Check each taken word, then pick the next ready level
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) check_word();
    rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 15);
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty table straight out of reset
  task automatic test_empty_volume();
    read_block(0);
    read_block(6);
    read_block(svbm_pkg::INDEX_BASE);
    read_block(svbm_pkg::DATA_START);
    write_block(svbm_pkg::DATA_START);
  endtask

  // Every region of the block map against a small table
  task automatic test_decode_map();
    send_cmd(svbm_pkg::OP_CLEAR, '1, '1, 1'b1);
    append_file(0, 1'b0);
    append_file(513, 1'b0);
    append_file(21'h1FFFFF, 1'b0);   // saturates at 1 MiB
    append_file(4096, 1'b1);
    append_file(1, 1'b0);
    read_block(1);
    read_block(2);
    read_block(5);
    read_block(svbm_pkg::INDEX_BASE - 1);
    read_block(svbm_pkg::SUBDIR_START);
    read_block(svbm_pkg::SUBDIR_START + 4 * svbm_pkg::ROOT_LIMIT - 1);
    read_block(svbm_pkg::INDEX_BASE + 2);    // pointers past the first half of the block
    read_block(svbm_pkg::INDEX_BASE + 1);
    read_block(svbm_pkg::INDEX_BASE + 31);   // slot beyond the entry count
    read_block(svbm_pkg::DATA_START - 1);    // slot above 31 wraps in file_number
    read_block(svbm_pkg::DATA_START + svbm_pkg::FILE_SPAN + 1);
    read_block(svbm_pkg::DATA_START + 3 * svbm_pkg::FILE_SPAN);  // directory reads as zero
    read_block(svbm_pkg::DATA_START + svbm_pkg::MAX_ENTRIES * svbm_pkg::FILE_SPAN);
    read_block(24'hFFFFFF);
  endtask

  // Writes to fixed areas, refused targets and a growing file
  task automatic test_block_writes();
    write_block(0);
    write_block(svbm_pkg::DATA_START - 1);
    write_block(svbm_pkg::SUBDIR_START);     // lands in the data of file 0
    write_block(svbm_pkg::DATA_START + 3 * svbm_pkg::FILE_SPAN);
    write_block(svbm_pkg::DATA_START + svbm_pkg::MAX_ENTRIES * svbm_pkg::FILE_SPAN - 1);
    write_block(24'hFFFFFF);
    write_block(svbm_pkg::DATA_START + svbm_pkg::FILE_SPAN + 5);
    read_block(6);
    read_block(svbm_pkg::INDEX_BASE + 1);
  endtask

  // Fill the table and push one entry past the end
  task automatic test_full_table();
    send_cmd(svbm_pkg::OP_CLEAR, '0, '0, 1'b0);
    append_file(svbm_pkg::SIZE_CAP, 1'b0);
    for (int i = 1; i <= svbm_pkg::MAX_ENTRIES; i++) begin
      append_file($urandom_range(0, 40000), ($urandom_range(0, 7) == 0));
    end
    read_block(svbm_pkg::INDEX_BASE + svbm_pkg::MAX_ENTRIES - 1);
    read_block(svbm_pkg::INDEX_BASE - 1);
    read_block(svbm_pkg::DATA_START + (svbm_pkg::MAX_ENTRIES - 1) * svbm_pkg::FILE_SPAN);
  endtask

  // Data block in or just past a listed file, now and then past the table
  function automatic int unsigned aim_data_block();
    int unsigned slot;
    int unsigned span;
    slot = $urandom_range(0, file_count);
    span = (slot < file_count) ? blocks_of(slot) + 2 : 8;
    if (span > svbm_pkg::FILE_SPAN) span = svbm_pkg::FILE_SPAN;
    return svbm_pkg::DATA_START + slot * svbm_pkg::FILE_SPAN + $urandom_range(0, span - 1);
  endfunction

  task automatic test_random(int n);
    int unsigned pick;
    int unsigned aim;
    int unsigned sz;
    for (int i = 0; i < n; i++) begin
      steady = (i >= 20 && i < 40);
      if (i == 45) await_results();
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        send_cmd(svbm_pkg::OP_CLEAR, svbm_pkg::BLOCK_W'($urandom),
                 svbm_pkg::SIZE_W'($urandom), 1'($urandom));
      end else if (pick < 25) begin
        sz = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 21'h1FFFFF)
                                         : $urandom_range(0, 150000);
        send_cmd(svbm_pkg::OP_APPEND, svbm_pkg::BLOCK_W'($urandom),
                 svbm_pkg::SIZE_W'(sz), ($urandom_range(0, 4) == 0));
      end else if (pick < 70) begin
        case ($urandom_range(0, 9))
          0: aim = $urandom_range(0, 1);
          1: aim = $urandom_range(2, 5);
          2: aim = $urandom_range(6, svbm_pkg::INDEX_BASE - 1);
          3: aim = $urandom_range(svbm_pkg::SUBDIR_START,
                                  svbm_pkg::SUBDIR_START + 4 * svbm_pkg::ROOT_LIMIT - 1);
          4: aim = (file_count > 0 && $urandom_range(0, 1) == 0)
                   ? svbm_pkg::INDEX_BASE + $urandom_range(0, file_count - 1)
                   : $urandom_range(svbm_pkg::INDEX_BASE, svbm_pkg::DATA_START - 1);
          8: aim = $urandom_range(0, 24'hFFFFFF);
          9: aim = $urandom_range(svbm_pkg::DATA_START, svbm_pkg::DATA_START
                                  + svbm_pkg::MAX_ENTRIES * svbm_pkg::FILE_SPAN + 100);
          default: aim = aim_data_block();
        endcase
        send_cmd(svbm_pkg::OP_READ, svbm_pkg::BLOCK_W'(aim),
                 svbm_pkg::SIZE_W'($urandom), 1'($urandom));
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 75) aim = aim_data_block();
        else if (pick < 85) aim = $urandom_range(0, svbm_pkg::DATA_START - 1);
        else aim = $urandom_range(0, 24'hFFFFFF);
        send_cmd(svbm_pkg::OP_WRITE, svbm_pkg::BLOCK_W'(aim),
                 svbm_pkg::SIZE_W'($urandom), 1'($urandom));
      end
    end
    steady = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst                       <= 1'b1;
    cmd_ch.valid              <= 1'b0;
    cmd_ch.operation          <= svbm_pkg::OP_CLEAR;
    cmd_ch.block_number       <= '0;
    cmd_ch.entry_size         <= '0;
    cmd_ch.entry_is_directory <= 1'b0;
    steady        = 1'b0;
    failures      = 0;
    file_count    = 0;
    for (int i = 0; i < svbm_pkg::MAX_ENTRIES; i++) begin
      file_size[i]   = '0;
      file_is_dir[i] = 1'b0;
      file_live[i]   = 1'b0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_volume();
    await_results();
    test_decode_map();
    await_results();
    test_block_writes();
    await_results();
    test_full_table();
    await_results();
    test_random(60);
    await_results();
    repeat (20) @(posedge clk);

    $display("Ran %0d commands (%0d block reads, %0d refused writes), checked %0d words",
             commands_sent, reads_sent, writes_refused, words_checked);
    $display("Words per region: boot %0d dir %0d bitmap %0d subdir %0d",
             region_hits[0], region_hits[1], region_hits[2], region_hits[3]);
    $display("  index %0d data %0d zero %0d ack %0d",
             region_hits[4], region_hits[5], region_hits[6], region_hits[7]);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
